/* hdl/tpt_pkg.sv */
// tpt_pkg: shared types and codes for the transport position tracker.
// No dependencies; imported by tpt_cfg_if and every module.
package tpt_pkg;

  // command codes
  localparam logic [3:0] OP_TICK      = 4'd0;
  localparam logic [3:0] OP_PLAY      = 4'd1;
  localparam logic [3:0] OP_STOP      = 4'd2;
  localparam logic [3:0] OP_PAUSE     = 4'd3;
  localparam logic [3:0] OP_RESUME    = 4'd4;
  localparam logic [3:0] OP_REC_START = 4'd5;
  localparam logic [3:0] OP_REC_STOP  = 4'd6;
  localparam logic [3:0] OP_LOOP_ON   = 4'd7;
  localparam logic [3:0] OP_LOOP_OFF  = 4'd8;

  // transport modes
  localparam logic [1:0] MODE_STOPPED   = 2'd0;
  localparam logic [1:0] MODE_PREPARING = 2'd1;
  localparam logic [1:0] MODE_PLAYING   = 2'd2;
  localparam logic [1:0] MODE_PAUSED    = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_END   = 2'd2;

  localparam logic [15:0] BLOCK_SIZE_RST = 16'd256;
  localparam logic [31:0] LOOP_START_RST = 32'd0;
  localparam logic [31:0] LOOP_END_RST   = 32'd384000;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] frames_passed;
  } cmd_t;

  typedef struct packed {
    logic [31:0] position;
    logic [1:0]  transport_mode;
    logic        is_recording;
    logic        loop_running;
  } res_t;

  typedef struct packed {
    logic [15:0] block_size;
    logic [31:0] loop_start;
    logic [31:0] loop_end;
  } cfg_t;

endpackage

/* hdl/tpt_ifs.sv */
// Channel interfaces: command in, result out, configuration write.
// Depends on tpt_pkg.
interface tpt_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [31:0] frames_passed;
  modport source (output valid, op, frames_passed, input ready);
  modport sink (input valid, op, frames_passed, output ready);
endinterface

interface tpt_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] position;
  logic [1:0]  transport_mode;
  logic        is_recording;
  logic        loop_running;
  modport source (output valid, position, transport_mode, is_recording, loop_running,
                  input ready);
  modport sink (input valid, position, transport_mode, is_recording, loop_running,
                output ready);
endinterface

interface tpt_cfg_if import tpt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/tpt_cfg.sv */
// tpt_cfg: configuration register file (block size, loop bounds).
// Depends on tpt_pkg and tpt_cfg_if.
module tpt_cfg import tpt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tpt_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.block_size <= BLOCK_SIZE_RST;
      regs.loop_start <= LOOP_START_RST;
      regs.loop_end   <= LOOP_END_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BLOCK_SIZE: regs.block_size <= cfg.data[15:0];
        REG_LOOP_START: regs.loop_start <= cfg.data;
        REG_LOOP_END:   regs.loop_end   <= cfg.data;
        default: ; // unused index, write dropped
      endcase
    end
  end

endmodule

/* hdl/tpt_core.sv */
// tpt_core: transport state and the single-pass command/tick evaluation.
// Depends on tpt_pkg.
module tpt_core import tpt_pkg::*; #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,   // staged word moves to the result register
  input  cmd_t cmd,
  input  cfg_t regs,
  output res_t res
);

  typedef logic [FRAME_BITS-1:0] frame_t;

  // state
  logic [1:0] run_mode, run_mode_next;
  frame_t     start_frame, start_frame_next;
  frame_t     pause_frame, pause_frame_next;
  frame_t     loop_stamp, loop_stamp_next;
  logic       loop_wrapped, loop_wrapped_next;
  logic       resume_pending, resume_pending_next;
  logic       recording_flag, recording_flag_next;
  logic       loop_on, loop_on_next;

  frame_t now, bs, ls, le;
  frame_t held, pos_raw, calc, pos;

  assign now = frame_t'(cmd.frames_passed);
  assign bs  = frame_t'(regs.block_size);
  assign ls  = frame_t'(regs.loop_start);
  assign le  = frame_t'(regs.loop_end);

  // resumed offset: now - (now - held) collapses to held
  assign held    = pause_frame - start_frame;
  assign pos_raw = resume_pending ? held : now - start_frame;
  assign calc    = (pos_raw - loop_stamp) + (loop_wrapped ? ls : '0);

  always_comb begin
    run_mode_next       = run_mode;
    start_frame_next    = start_frame;
    pause_frame_next    = pause_frame;
    loop_stamp_next     = loop_stamp;
    loop_wrapped_next   = loop_wrapped;
    resume_pending_next = resume_pending;
    recording_flag_next = recording_flag;
    loop_on_next        = loop_on;
    pos                 = '0;

    unique case (cmd.op)
      OP_TICK: begin
        unique case (run_mode)
          MODE_PLAYING: begin
            if (resume_pending) begin
              resume_pending_next = 1'b0;
              start_frame_next    = now - held;
            end
            pos = pos_raw;
            if (loop_on) begin
              if (calc > ls && (calc + bs) >= le) begin
                loop_stamp_next   = pos_raw + bs;
                loop_wrapped_next = 1'b1;
              end
              pos = calc;
            end
          end
          MODE_PREPARING: begin
            start_frame_next = now + bs;
            run_mode_next    = MODE_PLAYING;
          end
          MODE_PAUSED: pause_frame_next = now;
          default: ; // stopped
        endcase
      end
      OP_PLAY: begin
        start_frame_next  = '0;
        loop_wrapped_next = 1'b0;
        loop_stamp_next   = '0;
        run_mode_next     = MODE_PREPARING;
      end
      OP_STOP: begin
        recording_flag_next = 1'b0;
        start_frame_next    = '0;
        run_mode_next       = MODE_STOPPED;
      end
      OP_PAUSE: run_mode_next = MODE_PAUSED;
      OP_RESUME: begin
        resume_pending_next = 1'b1;
        run_mode_next       = MODE_PLAYING;
      end
      OP_REC_START: begin
        if (!recording_flag) begin
          if (run_mode != MODE_PLAYING) begin
            start_frame_next  = '0;
            loop_wrapped_next = 1'b0;
            loop_stamp_next   = '0;
            run_mode_next     = MODE_PREPARING;
          end
          recording_flag_next = 1'b1;
        end
      end
      OP_REC_STOP: recording_flag_next = 1'b0;
      OP_LOOP_ON: begin
        loop_on_next    = 1'b1;
        loop_stamp_next = '0;
      end
      OP_LOOP_OFF: begin
        loop_on_next     = 1'b0;
        start_frame_next = start_frame + loop_stamp;
      end
      default: ; // unknown op: status only
    endcase
  end

  always_comb begin
    res.position       = 32'(pos);
    res.transport_mode = run_mode_next;
    res.is_recording   = recording_flag_next;
    res.loop_running   = loop_wrapped_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode       <= MODE_STOPPED;
      start_frame    <= '0;
      pause_frame    <= '0;
      loop_stamp     <= '0;
      loop_wrapped   <= 1'b0;
      resume_pending <= 1'b0;
      recording_flag <= 1'b0;
      loop_on        <= 1'b0;
    end else if (fire) begin
      run_mode       <= run_mode_next;
      start_frame    <= start_frame_next;
      pause_frame    <= pause_frame_next;
      loop_stamp     <= loop_stamp_next;
      loop_wrapped   <= loop_wrapped_next;
      resume_pending <= resume_pending_next;
      recording_flag <= recording_flag_next;
      loop_on        <= loop_on_next;
    end
  end

`ifndef SYNTHESIS
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.op == OP_STOP |=> run_mode == MODE_STOPPED && !recording_flag
      && start_frame == '0)
    else $error("stop did not clear transport");

  a_play_arms: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.op == OP_PLAY |=> run_mode == MODE_PREPARING && !loop_wrapped
      && loop_stamp == '0)
    else $error("play did not enter preparing");

  a_prep_tick: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.op == OP_TICK && run_mode == MODE_PREPARING
      |=> run_mode == MODE_PLAYING)
    else $error("first tick after play did not start playback");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(run_mode) && $stable(start_frame) && $stable(recording_flag))
    else $error("state changed without a word");
`endif

endmodule

/* hdl/transport_position_tracker.sv */
// transport_position_tracker: top level; input stage, core, result register.
// Depends on tpt_pkg, tpt_ifs, tpt_cfg and tpt_core.
//
//   channel | dir | words carried
//   --------+-----+--------------------------------------------------
//   cmd     | in  | op, frames_passed
//   res     | out | position, transport_mode, is_recording, loop_running
//   cfg     | in  | index, data (block_size, loop_start, loop_end)
//
// One word per cycle sustained while res is ready. An accepted cmd word goes
// via the input stage, then the core evaluation, to the result register.
// The state update happens when the staged word moves into the result
// register, so each word sees the state left by the one before it.
// A stalled res holds its word; the input stage keeps taking words until it
// too is full. Reset (synchronous, rst high) empties both stages, restores
// the transport state and loads the configuration defaults. cfg is always
// ready and takes effect at once.
module transport_position_tracker import tpt_pkg::*; #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  tpt_cmd_if.sink    cmd,
  tpt_res_if.source  res,
  tpt_cfg_if.sink    cfg
);

  cfg_t regs;
  cmd_t stg_cmd;
  logic stg_valid;
  res_t core_res;
  res_t out_res;
  logic out_valid;
  logic advance;

  // staged word moves on when the result slot is free or being emptied
  assign advance   = stg_valid && (!out_valid || res.ready);
  assign cmd.ready = !stg_valid || advance;

  tpt_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tpt_core #(.FRAME_BITS(FRAME_BITS)) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .cmd  (stg_cmd),
    .regs (regs),
    .res  (core_res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (cmd.ready) begin
      stg_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      stg_cmd.op            <= cmd.op;
      stg_cmd.frames_passed <= cmd.frames_passed;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign res.valid          = out_valid;
  assign res.position       = out_res.position;
  assign res.transport_mode = out_res.transport_mode;
  assign res.is_recording   = out_res.is_recording;
  assign res.loop_running   = out_res.loop_running;

endmodule

/* verif/tb.sv */
// tb: self-checking bench for transport_position_tracker (play, pause, loop, record).
// Depends on tpt_pkg, tpt_ifs and transport_position_tracker from hdl/. A predictor runs alongside the DUT and
// a checker compares each returned word with the predicted status.
`timescale 1ns / 100ps

module tb;
  import tpt_pkg::*;

  // codes outside the defined command set; the DUT must leave its state alone
  localparam logic [3:0] OP_BAD_LO = 4'd9;
  localparam logic [3:0] OP_BAD_HI = 4'd15;

  localparam int STALL_LIMIT   = 4000; // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES = 6;    // pipeline is two deep; a few spare

  logic clk = 1'b0;
  logic rst;

  always #2 clk = ~clk;

  tpt_cmd_if cmd_ch ();
  tpt_res_if res_ch ();
  tpt_cfg_if cfg_ch ();

  transport_position_tracker dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: configuration copy and transport state
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_block;
  logic [31:0] cfg_loop_lo;
  logic [31:0] cfg_loop_hi;

  logic [1:0]  trk_mode;
  logic [31:0] trk_start;
  logic [31:0] trk_pause;
  logic [31:0] trk_stamp;
  logic        trk_wrapped;
  logic        trk_resume;
  logic        trk_rec;
  logic        trk_loop;

  res_t        status_q[$];   // predicted status words, oldest first
  res_t        want_word;
  int          mismatches = 0;
  int          gap_pct    = 13; // idle / stall odds, percent, both sides
  int          quiet_cycles = 0;
  logic [31:0] frame_clk;     // absolute frame counter for ticks, stepped and jumped by the session

  // Play (and record start from a non-playing mode) restarts from scratch.
  function void restart_play();
    trk_start   = '0;
    trk_wrapped = 1'b0;
    trk_stamp   = '0;
    trk_mode    = MODE_PREPARING;
  endfunction

  // Apply one command to the predicted transport and return the status word.
  function automatic res_t advance_transport(logic [3:0] op, logic [31:0] now);
    res_t        r;
    logic [31:0] pos;
    logic [31:0] held;
    logic [31:0] calc;
    logic [31:0] reach;
    pos = '0;
    case (op)
      OP_TICK: begin
        if (trk_mode == MODE_PLAYING) begin
          // resume reapplies the offset held at pause against the new frame
          if (trk_resume) begin
            held       = trk_pause - trk_start;
            trk_resume = 1'b0;
            trk_start  = now - held;
          end
          pos = now - trk_start;
          if (trk_loop) begin
            calc = pos - trk_stamp;
            if (trk_wrapped)
              calc = calc + cfg_loop_lo;
            // wrap one block early; all compares on wrapped 32-bit values
            reach = calc + 32'(cfg_block);
            if (calc > cfg_loop_lo && reach >= cfg_loop_hi) begin
              trk_stamp   = pos + 32'(cfg_block);
              trk_wrapped = 1'b1;
            end
            pos = calc;
          end
        end else if (trk_mode == MODE_PREPARING) begin
          // first tick after play latches the start one block ahead
          trk_start = now + 32'(cfg_block);
          trk_mode  = MODE_PLAYING;
        end else if (trk_mode == MODE_PAUSED) begin
          trk_pause = now;
        end
      end
      OP_PLAY: restart_play();
      OP_STOP: begin
        trk_rec   = 1'b0;
        trk_start = '0;
        trk_mode  = MODE_STOPPED;
      end
      OP_PAUSE: trk_mode = MODE_PAUSED;
      OP_RESUME: begin
        trk_resume = 1'b1;
        trk_mode   = MODE_PLAYING;
      end
      OP_REC_START: begin
        if (!trk_rec) begin
          if (trk_mode != MODE_PLAYING)
            restart_play();
          trk_rec = 1'b1;
        end
      end
      OP_REC_STOP: trk_rec = 1'b0;
      OP_LOOP_ON: begin
        trk_loop  = 1'b1;
        trk_stamp = '0;
      end
      OP_LOOP_OFF: begin
        // stamp folds into start every time, even with loop already off
        trk_loop  = 1'b0;
        trk_start = trk_start + trk_stamp;
      end
      default: ;
    endcase
    r.position       = pos;
    r.transport_mode = trk_mode;
    r.is_recording   = trk_rec;
    r.loop_running   = trk_wrapped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // result sink: random back-pressure
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= gap_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (status_q.size() == 0) begin
        note_mismatch("word with nothing expected", res_ch.position, '0);
      end else begin
        want_word = status_q.pop_front();
        if (res_ch.position !== want_word.position)
          note_mismatch("position", res_ch.position, want_word.position);
        if (res_ch.transport_mode !== want_word.transport_mode)
          note_mismatch("transport_mode", 32'(res_ch.transport_mode),
                        32'(want_word.transport_mode));
        if (res_ch.is_recording !== want_word.is_recording)
          note_mismatch("is_recording", 32'(res_ch.is_recording),
                        32'(want_word.is_recording));
        if (res_ch.loop_running !== want_word.loop_running)
          note_mismatch("loop_running", 32'(res_ch.loop_running),
                        32'(want_word.loop_running));
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Send one command word; predict once the DUT has taken it.
  task automatic send_cmd(logic [3:0] op, logic [31:0] frames);
    while ($urandom_range(99) < gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.op            <= op;
    cmd_ch.frames_passed <= frames;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    status_q.push_back(advance_transport(op, frames));
  endtask

  // Hold off commands until every predicted word has come back.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (status_q.size() != 0);
  endtask

  // Quiesce, then write all three registers back to back.
  task automatic set_config(logic [15:0] bs, logic [31:0] lo, logic [31:0] hi);
    logic [CFG_IDX_W-1:0] idxs[3];
    logic [31:0]          vals[3];
    idxs = '{REG_BLOCK_SIZE, REG_LOOP_START, REG_LOOP_END};
    vals = '{{16'h0, bs}, lo, hi};
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idxs[i];
      cfg_ch.data  <= vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (idxs[i])
        REG_BLOCK_SIZE: cfg_block   = vals[i][15:0];
        REG_LOOP_START: cfg_loop_lo = vals[i];
        REG_LOOP_END:   cfg_loop_hi = vals[i];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // A transport session: play, then mostly ticks advancing by about a block,
  // mixed with the other commands, odd frames, unknown codes and drains.
  task automatic play_session(int n_words);
    int          pick;
    logic [31:0] step;
    frame_clk = $urandom;
    send_cmd(OP_PLAY, $urandom);
    repeat (n_words - 1) begin
      pick = $urandom_range(99);
      step = (cfg_block == 16'd0) ? $urandom_range(1, 64) :
             32'(cfg_block) + $urandom_range(0, 3);
      if (pick < 60) begin
        frame_clk = frame_clk + step;
        send_cmd(OP_TICK, frame_clk);
      end
      else if (pick < 65) send_cmd(OP_PAUSE, $urandom);
      else if (pick < 70) send_cmd(OP_RESUME, $urandom);
      else if (pick < 74) send_cmd(OP_PLAY, $urandom);
      else if (pick < 77) send_cmd(OP_STOP, $urandom);
      else if (pick < 81) send_cmd(OP_REC_START, $urandom);
      else if (pick < 84) send_cmd(OP_REC_STOP, $urandom);
      else if (pick < 88) send_cmd(OP_LOOP_ON, $urandom);
      else if (pick < 91) send_cmd(OP_LOOP_OFF, $urandom);
      else if (pick < 94) send_cmd(OP_TICK, $urandom);
      else if (pick < 96) send_cmd(4'($urandom_range(OP_BAD_LO, OP_BAD_HI)), $urandom);
      else if (pick < 98) begin
        // jump the counter just short of its wrap point
        frame_clk = 32'hFFFF_FFFF - $urandom_range(0, 3 * 65536);
        send_cmd(OP_TICK, frame_clk);
      end
      else begin
        drain_results();
        send_cmd(OP_TICK, frame_clk);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Hand-picked sequence at reset configuration (block 256, loop 0..384000).
  task automatic test_directed();
    send_cmd(OP_TICK, 32'h0000_0000);       // tick while stopped
    send_cmd(OP_TICK, 32'hFFFF_FFFF);
    send_cmd(OP_BAD_LO, 32'hFFFF_FFFF);     // unknown code
    send_cmd(OP_LOOP_OFF, 32'h0);           // loop off while off
    send_cmd(OP_PAUSE, 32'h0);              // pause from stopped
    send_cmd(OP_TICK, 32'd1234);            // tick while paused records frame
    send_cmd(OP_RESUME, 32'h0);             // resume from paused
    send_cmd(OP_TICK, 32'd5000);            // held offset reapplied
    send_cmd(OP_STOP, 32'h0);
    send_cmd(OP_REC_START, 32'h0);          // record from stopped: plays first
    send_cmd(OP_REC_START, 32'h0);          // already recording: ignored
    send_cmd(OP_TICK, 32'hFFFF_FF00);       // start latched wraps to zero
    send_cmd(OP_TICK, 32'h0000_0100);
    send_cmd(OP_LOOP_ON, 32'h0);
    send_cmd(OP_TICK, 32'h0000_0200);
    send_cmd(OP_TICK, 32'd384000);          // within a block of loop end: wraps
    send_cmd(OP_TICK, 32'd384300);
    send_cmd(OP_REC_STOP, 32'h0);
    send_cmd(OP_LOOP_OFF, 32'h0);           // stamp folds into start
    send_cmd(OP_TICK, 32'd400000);
    send_cmd(OP_PAUSE, 32'h0);
    send_cmd(OP_REC_START, 32'h0);          // record while paused: plays first
    send_cmd(OP_PLAY, 32'hFFFF_FFFF);
    send_cmd(OP_BAD_HI, 32'h0);
    send_cmd(OP_STOP, 32'hFFFF_FFFF);
  endtask

  // Smallest, largest and zero block size with loops short enough to wrap.
  task automatic test_block_sizes();
    set_config(16'd1, 32'd0, 32'd64);
    play_session(150);
    set_config(16'hFFFF, 32'd100000, 32'd600000);
    play_session(150);
    set_config(16'd0, 32'd10, 32'd300);
    play_session(120);
  endtask

  // Loop bounds at the ends of the range.
  task automatic test_loop_bounds();
    set_config(16'($urandom_range(1, 65535)), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    play_session(100);
    set_config(16'd4096, 32'd0, 32'd0);
    play_session(120);
    set_config(16'd512, 32'd0, 32'hFFFF_FFFF);
    play_session(60);
  endtask

  // Random loop regions between one and 40 blocks long.
  task automatic test_random_loops();
    logic [15:0] bs;
    logic [31:0] lo;
    repeat (3) begin
      bs = 16'($urandom_range(1, 2048));
      lo = $urandom_range(0, 30 * int'(bs));
      set_config(bs, lo, lo + $urandom_range(1, 40) * 32'(bs));
      play_session(130);
    end
  endtask

  // Long stretch at full rate on both sides.
  task automatic test_back_to_back();
    set_config(16'd256, 32'd1000, 32'd1000 + 32'd20 * 32'd256);
    gap_pct = 0;
    play_session(250);
    gap_pct = 13;
  endtask

  initial begin
    rst                  <= 1'b1;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.op            <= OP_TICK;
    cmd_ch.frames_passed <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_BLOCK_SIZE;
    cfg_ch.data          <= '0;

    cfg_block   = BLOCK_SIZE_RST;
    cfg_loop_lo = LOOP_START_RST;
    cfg_loop_hi = LOOP_END_RST;
    trk_mode    = MODE_STOPPED;
    trk_start   = '0;
    trk_pause   = '0;
    trk_stamp   = '0;
    trk_wrapped = 1'b0;
    trk_resume  = 1'b0;
    trk_rec     = 1'b0;
    trk_loop    = 1'b0;
    frame_clk   = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_block_sizes();
    test_loop_bounds();
    test_random_loops();
    test_back_to_back();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/tpt_pkg.sv
hdl/tpt_ifs.sv
hdl/tpt_cfg.sv
hdl/tpt_core.sv
hdl/transport_position_tracker.sv
verif/tb.sv
